[rtl/msr_pkg.sv]
// Package for the MESI snoop resolver: state encoding, lane and result types,
// configuration register indexes and shared constants. No dependencies.
package msr_pkg;

  localparam int NUM_LANES = 4;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_state_t;

  typedef enum logic {
    CFG_BLOCK_BYTES = 1'b0,
    CFG_MEM_LATENCY = 1'b1
  } cfg_index_t;

  localparam logic [2:0] NO_SUPPLIER = 3'd4;
  localparam logic [10:0] BLOCK_BYTES_RST = 11'd32;
  localparam logic [9:0] MEM_LATENCY_RST = 10'd100;

  typedef struct packed {
    mesi_state_t new_state;
    logic        holds;
    logic        writeback;
  } lane_res_t;

  // Declared from the highest bit down so that it packs as the result tdata.
  typedef struct packed {
    logic        bus_invalidate;
    logic [2:0]  supplier;
    logic [12:0] total_cycles;
    logic [9:0]  fill_cycles;
    logic [11:0] writeback_cycles;
    logic [3:0]  writeback_mask;
    mesi_state_t new_state_3;
    mesi_state_t new_state_2;
    mesi_state_t new_state_1;
    mesi_state_t new_state_0;
    mesi_state_t requester_state;
    logic [31:0] line_echo;
  } res_t;

endpackage

[rtl/msr_lane.sv]
// One snoop lane: resolves the new state of one cache for a bus request.
// Depends on msr_pkg.
module msr_lane import msr_pkg::*; #(
  parameter int LANE_IDX = 0,
  parameter bit PRESENT  = 1'b1
) (
  input  logic [1:0] requester,
  input  logic       rdx,
  input  logic [1:0] snoop_state,
  output lane_res_t  res
);

  logic is_req;
  logic held;

  assign is_req = (requester == 2'(LANE_IDX));
  assign held   = (mesi_state_t'(snoop_state) != ST_I);

  always_comb begin
    res = '{new_state: ST_I, holds: 1'b0, writeback: 1'b0};
    if (PRESENT) begin
      if (is_req) begin
        res.new_state = mesi_state_t'(snoop_state);
      end else if (held) begin
        res.holds     = 1'b1;
        res.writeback = (mesi_state_t'(snoop_state) == ST_M);
        res.new_state = rdx ? ST_I : ST_S;
      end
    end
  end

endmodule

[rtl/msr_merge.sv]
// Merge stage: combines the lane findings into supplier, write-back and fill
// costs and the requester's final state. Depends on msr_pkg.
module msr_merge import msr_pkg::*; (
  input  lane_res_t   lanes [NUM_LANES],
  input  logic        rdx,
  input  logic        upg,
  input  logic [31:0] line_address,
  input  logic [9:0]  evict_penalty,
  input  logic [10:0] block_bytes,
  input  logic [9:0]  mem_latency,
  output res_t        res
);

  logic [2:0]  supplier;
  logic [2:0]  wb_count;
  logic [3:0]  wb_mask;
  logic [12:0] wb_prod;
  logic [9:0]  fill;
  logic        any_holder;

  always_comb begin
    supplier = NO_SUPPLIER;
    wb_count = 3'd0;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (lanes[i].holds) begin
        supplier = 3'(i);
      end
      wb_mask[i] = lanes[i].writeback;
      wb_count   = wb_count + 3'(lanes[i].writeback);
    end
  end

  assign any_holder = (supplier != NO_SUPPLIER);
  assign wb_prod    = 13'(mem_latency) * 13'(wb_count);

  always_comb begin
    if (rdx && upg) begin
      fill = 10'd1;
    end else if (any_holder) begin
      fill = block_bytes[10:1];
    end else begin
      fill = mem_latency;
    end
  end

  always_comb begin
    res.line_echo        = line_address;
    res.requester_state  = rdx ? ST_M : (any_holder ? ST_S : ST_E);
    res.new_state_0      = lanes[0].new_state;
    res.new_state_1      = lanes[1].new_state;
    res.new_state_2      = lanes[2].new_state;
    res.new_state_3      = lanes[3].new_state;
    res.writeback_mask   = wb_mask;
    res.writeback_cycles = wb_prod[11:0];
    res.fill_cycles      = fill;
    res.total_cycles     = 13'(evict_penalty) + 13'(wb_prod[11:0]) + 13'(fill);
    res.supplier         = supplier;
    res.bus_invalidate   = rdx & (upg | any_holder);
  end

endmodule

[rtl/mesi_snoop_resolver_core.sv]
// MESI snoop resolver top level: four snoop lanes, a merge stage and a
// two-entry output buffer; the result is registered. Throughput is one request
// per cycle while the skid entry is empty; the output register and a skid entry
// keep requests flowing while a result waits for the consumer.
// Synchronous active-low reset empties the buffer and sets block_bytes to 32
// and mem_latency to 100. Depends on msr_pkg, msr_lane and msr_merge.
module mesi_snoop_resolver_core import msr_pkg::*; #(
  parameter int NUM_CACHES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // requester, line_address, snoop_state_0..3, evict_penalty, zero pad
  input  logic [55:0] in_tdata,
  // cmd, upgrade_only
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // line_echo, requester_state, new_state_0..3, writeback_mask,
  // writeback_cycles, fill_cycles, total_cycles, supplier, bus_invalidate, pad
  output logic [87:0] out_tdata
);

  logic [10:0] block_bytes_r;
  logic [9:0]  mem_latency_r;
  lane_res_t   lanes [NUM_LANES];
  res_t        res;
  res_t        out_r, out_nxt, skid_r, skid_nxt;
  logic        out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic        accept;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r <= BLOCK_BYTES_RST;
      mem_latency_r <= MEM_LATENCY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_BLOCK_BYTES: block_bytes_r <= cfg_wdata;
        CFG_MEM_LATENCY: mem_latency_r <= cfg_wdata[9:0];
      endcase
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    msr_lane #(
      .LANE_IDX(i),
      .PRESENT (i < NUM_CACHES)
    ) u_lane (
      .requester  (in_tdata[1:0]),
      .rdx        (in_tuser[0]),
      .snoop_state(in_tdata[35 + 2 * i -: 2]),
      .res        (lanes[i])
    );
  end

  msr_merge u_merge (
    .lanes        (lanes),
    .rdx          (in_tuser[0]),
    .upg          (in_tuser[1]),
    .line_address (in_tdata[33:2]),
    .evict_penalty(in_tdata[51:42]),
    .block_bytes  (block_bytes_r),
    .mem_latency  (mem_latency_r),
    .res          (res)
  );

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_nxt        = skid_valid_r ? skid_r : res;
      out_valid_nxt  = skid_valid_r || accept;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

endmodule

[rtl/msr_checker.sv]
// Port-level checker for the MESI snoop resolver, bound to the top level.
// Depends only on the top level's ports.
module msr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_fill_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> out_tvalid)
    else $error("accepted request did not appear one cycle later");

  a_req_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd0)
    else $error("requester left in invalid state");

  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[45:42] == 4'd0 |-> out_tdata[57:46] == 12'd0)
    else $error("write-back cycles without write-backs");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:68] >= 13'(out_tdata[57:46]) + 13'(out_tdata[67:58]))
    else $error("total below write-back plus fill");

endmodule

bind mesi_snoop_resolver_core msr_checker u_msr_checker (.*);

[sim/mesi_snoop_resolver_core_test.sv]
// Self-checking testbench for mesi_snoop_resolver_core: a directed table of bus requests,
// then random phases over several line-size and memory-latency settings and handshake loads.
// Depends on msr_pkg and resolver RTL; checks results against known rows or a predictor.
module mesi_snoop_resolver_core_test;
  import msr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHES = 4;
  localparam int PHASE_ITEMS = 240;
  localparam int HOLD_PHASE = 4;
  localparam int PAUSE_PHASE = 6;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]      requester;
    logic            cmd;
    logic            upgrade;
    logic [31:0]     line;
    logic [3:0][1:0] snoop;
    logic [9:0]      evict;
  } bus_req_t;

  typedef struct {
    bus_req_t req;
    bit       known;
    res_t     res;
  } dir_row_t;

  typedef struct {
    bit   known;
    res_t res;
  } typed_t;

  typedef struct {
    int blk;
    int lat;
    int send_pct;
    int recv_pct;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [10:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;

  logic [10:0] blk_bytes = BLOCK_BYTES_RST;
  logic [9:0]  mem_lat = MEM_LATENCY_RST;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;

  res_t     pending_res[$];
  typed_t   typed_res[$];
  dir_row_t dir_rows[$];
  phase_t   plan[8];

  mesi_snoop_resolver_core #(.NUM_CACHES(CACHES)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic res_t resolve_snoop(bus_req_t r, logic [10:0] bb, logic [9:0] ml);
    res_t        o;
    mesi_state_t ns [4];
    mesi_state_t st;
    logic [2:0]  sup;
    logic [3:0]  wbm;
    logic [9:0]  fill;
    logic [11:0] wbc;
    logic        inv;
    mesi_state_t rs;
    int          wbn;
    sup = NO_SUPPLIER;
    wbm = '0;
    wbn = 0;
    inv = 1'b0;
    for (int i = 0; i < 4; i++) begin
      st = mesi_state_t'(r.snoop[i]);
      if (i >= CACHES) begin
        ns[i] = ST_I;
      end else if (i == r.requester) begin
        ns[i] = st;
      end else if (st != ST_I) begin
        if (sup == NO_SUPPLIER) sup = 3'(i);
        if (st == ST_M) begin
          wbm[i] = 1'b1;
          wbn++;
        end
        ns[i] = r.cmd ? ST_I : ST_S;
      end else begin
        ns[i] = ST_I;
      end
    end
    if (!r.cmd) begin
      if (sup == NO_SUPPLIER) begin
        fill = ml;
        rs = ST_E;
      end else begin
        fill = 10'(bb >> 1);
        rs = ST_S;
      end
    end else begin
      rs = ST_M;
      if (r.upgrade) begin
        fill = 10'd1;
        inv = 1'b1;
      end else if (sup == NO_SUPPLIER) begin
        fill = ml;
      end else begin
        fill = 10'(bb >> 1);
        inv = 1'b1;
      end
    end
    wbc = 12'(ml * wbn);
    o.line_echo = r.line;
    o.requester_state = rs;
    o.new_state_0 = ns[0];
    o.new_state_1 = ns[1];
    o.new_state_2 = ns[2];
    o.new_state_3 = ns[3];
    o.writeback_mask = wbm;
    o.writeback_cycles = wbc;
    o.fill_cycles = fill;
    o.total_cycles = 13'(r.evict) + 13'(wbc) + 13'(fill);
    o.supplier = sup;
    o.bus_invalidate = inv;
    return o;
  endfunction

  function automatic bus_req_t mk_req(int rq, bit cmd, bit upg, logic [31:0] line,
                                      mesi_state_t s3, mesi_state_t s2, mesi_state_t s1,
                                      mesi_state_t s0, int evict);
    bus_req_t r;
    r.requester = 2'(rq);
    r.cmd = cmd;
    r.upgrade = upg;
    r.line = line;
    r.snoop = {s3, s2, s1, s0};
    r.evict = 10'(evict);
    return r;
  endfunction

  function automatic res_t known_res(logic [31:0] line, mesi_state_t rs, mesi_state_t n0,
                                     mesi_state_t n1, mesi_state_t n2, mesi_state_t n3,
                                     int wbm, int wbc, int fill, int total, logic [2:0] sup,
                                     bit inv);
    res_t o;
    o.line_echo = line;
    o.requester_state = rs;
    o.new_state_0 = n0;
    o.new_state_1 = n1;
    o.new_state_2 = n2;
    o.new_state_3 = n3;
    o.writeback_mask = 4'(wbm);
    o.writeback_cycles = 12'(wbc);
    o.fill_cycles = 10'(fill);
    o.total_cycles = 13'(total);
    o.supplier = sup;
    o.bus_invalidate = inv;
    return o;
  endfunction

  function automatic bus_req_t rand_req();
    bus_req_t r;
    int       shape;
    int       ev;
    r.requester = 2'($urandom_range(3));
    r.cmd = 1'($urandom_range(1));
    r.upgrade = 1'($urandom_range(1));
    r.line = $urandom();
    shape = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      if (shape < 2 && i != r.requester) r.snoop[i] = ST_I;
      else r.snoop[i] = 2'($urandom_range(3));
    end
    ev = $urandom_range(9);
    if (ev == 0) r.evict = 10'd0;
    else if (ev == 1) r.evict = 10'd1023;
    else r.evict = 10'($urandom_range(1023));
    return r;
  endfunction

  task automatic add_row(bus_req_t req, bit known, res_t res);
    dir_row_t row;
    row.req = req;
    row.known = known;
    row.res = res;
    dir_rows = {dir_rows, row};
  endtask

  task automatic note_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp) note_error($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  task automatic compare_res(res_t got, res_t exp);
    check_field("line_echo", got.line_echo, exp.line_echo);
    check_field("requester_state", got.requester_state, exp.requester_state);
    check_field("new_state_0", got.new_state_0, exp.new_state_0);
    check_field("new_state_1", got.new_state_1, exp.new_state_1);
    check_field("new_state_2", got.new_state_2, exp.new_state_2);
    check_field("new_state_3", got.new_state_3, exp.new_state_3);
    check_field("writeback_mask", got.writeback_mask, exp.writeback_mask);
    check_field("writeback_cycles", got.writeback_cycles, exp.writeback_cycles);
    check_field("fill_cycles", got.fill_cycles, exp.fill_cycles);
    check_field("total_cycles", got.total_cycles, exp.total_cycles);
    check_field("supplier", got.supplier, exp.supplier);
    check_field("bus_invalidate", got.bus_invalidate, exp.bus_invalidate);
  endtask

  always @(posedge clk) begin
    res_t     got;
    res_t     exp;
    bus_req_t req;
    typed_t   t;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (pending_res.size() == 0) begin
          note_error($sformatf("result with no request waiting, line %0h", got.line_echo));
        end else begin
          exp = pending_res.pop_front();
          compare_res(got, exp);
        end
      end
      if (in_tvalid && in_tready) begin
        req.requester = in_tdata[1:0];
        req.line = in_tdata[33:2];
        req.snoop = in_tdata[41:34];
        req.evict = in_tdata[51:42];
        req.cmd = in_tuser[0];
        req.upgrade = in_tuser[1];
        exp = resolve_snoop(req, blk_bytes, mem_lat);
        if (typed_res.size() != 0) begin
          t = typed_res.pop_front();
          if (t.known) exp = t.res;
        end
        pending_res = {pending_res, exp};
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(bus_req_t r);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, r.evict, r.snoop, r.line, r.requester};
    in_tuser <= {r.upgrade, r.cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_res.size() != 0);
  endtask

  task automatic set_config(logic [10:0] bb, logic [9:0] ml);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BLOCK_BYTES;
    cfg_wdata <= bb;
    @(negedge clk);
    cfg_index <= CFG_MEM_LATENCY;
    cfg_wdata <= {1'b0, ml};
    @(negedge clk);
    cfg_we <= 1'b0;
    blk_bytes = bb;
    mem_lat = ml;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;

    add_row(mk_req(0, 0, 0, 32'h0, ST_I, ST_I, ST_I, ST_I, 0), 1'b1,
      known_res(32'h0, ST_E, ST_I, ST_I, ST_I, ST_I, 0, 0, 100, 100, NO_SUPPLIER, 0));
    add_row(mk_req(3, 1, 0, 32'hFFFFFFFF, ST_M, ST_I, ST_I, ST_I, 1023), 1'b1,
      known_res(32'hFFFFFFFF, ST_M, ST_I, ST_I, ST_I, ST_M, 0, 0, 100, 1123, NO_SUPPLIER, 0));
    add_row(mk_req(1, 1, 1, 32'h12345678, ST_M, ST_M, ST_S, ST_M, 0), 1'b1,
      known_res(32'h12345678, ST_M, ST_I, ST_S, ST_I, ST_I, 4'hD, 300, 1, 301, 3'd0, 1));
    add_row(mk_req(2, 0, 0, 32'hAAAAAAAA, ST_M, ST_M, ST_M, ST_M, 1023), 1'b1,
      known_res(32'hAAAAAAAA, ST_S, ST_S, ST_S, ST_M, ST_S, 4'hB, 300, 16, 1339, 3'd0, 0));
    add_row(mk_req(0, 0, 1, 32'h55555555, ST_I, ST_I, ST_S, ST_I, 7), 1'b0, '0);
    add_row(mk_req(1, 0, 0, 32'h0F0F0F0F, ST_E, ST_I, ST_I, ST_I, 1), 1'b0, '0);
    add_row(mk_req(3, 0, 0, 32'hF0F0F0F0, ST_I, ST_I, ST_I, ST_E, 2), 1'b0, '0);
    add_row(mk_req(2, 1, 0, 32'h1, ST_I, ST_E, ST_S, ST_I, 3), 1'b0, '0);
    add_row(mk_req(0, 1, 1, 32'h2, ST_I, ST_I, ST_I, ST_I, 4), 1'b0, '0);
    add_row(mk_req(1, 1, 0, 32'h3, ST_I, ST_I, ST_M, ST_I, 5), 1'b0, '0);
    add_row(mk_req(0, 0, 0, 32'h4, ST_I, ST_I, ST_I, ST_M, 6), 1'b0, '0);
    add_row(mk_req(3, 1, 1, 32'h80000000, ST_E, ST_E, ST_E, ST_E, 8), 1'b0, '0);
    add_row(mk_req(2, 0, 0, 32'h7FFFFFFF, ST_S, ST_I, ST_S, ST_S, 9), 1'b0, '0);
    add_row(mk_req(1, 1, 0, 32'hDEADBEEF, ST_M, ST_M, ST_M, ST_M, 1023), 1'b0, '0);
    add_row(mk_req(0, 1, 0, 32'h0, ST_S, ST_S, ST_S, ST_I, 512), 1'b0, '0);
    add_row(mk_req(3, 0, 1, 32'hFFFF0000, ST_I, ST_M, ST_I, ST_M, 256), 1'b0, '0);

    plan = '{
      '{32, 100, 0, 0},
      '{4, 1, 45, 0},
      '{1024, 1023, 0, 45},
      '{1, 1023, 23, 23},
      '{5, 512, 0, 0},
      '{1023, 1, 45, 0},
      '{1023, 777, 23, 23},
      '{64, 100, 0, 45}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      typed_res = {typed_res, typed_t'{dir_rows[i].known, dir_rows[i].res}};
      send_request(dir_rows[i].req);
    end

    foreach (plan[p]) begin
      wait_idle();
      repeat (2) @(negedge clk);
      set_config(11'(plan[p].blk), 10'(plan[p].lat));
      send_idle_pct = plan[p].send_pct;
      recv_stall_pct <= plan[p].recv_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == HOLD_PHASE && n == 30) hold_request <= 1'b1;
        if (p == PAUSE_PHASE && n == 120) wait_idle();
        send_request(rand_req());
      end
    end

    wait_idle();
    repeat (5) @(negedge clk);
    if (pending_res.size() != 0) note_error("results still expected at the end");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
